[design/tbc_pkg.sv]
// Shared types and constants for the thermistor averaging and beta conversion block.
`default_nettype none

package tbc_pkg;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_MUL_PN = 4'd2;
    localparam logic [3:0] S_MUL_PD = 4'd3;
    localparam logic [3:0] S_NORM   = 4'd4;
    localparam logic [3:0] S_SQ     = 4'd5;
    localparam logic [3:0] S_DIFF   = 4'd6;
    localparam logic [3:0] S_LN     = 4'd7;
    localparam logic [3:0] S_NUM    = 4'd8;
    localparam logic [3:0] S_DENA   = 4'd9;
    localparam logic [3:0] S_DENB   = 4'd10;
    localparam logic [3:0] S_DENCHK = 4'd11;
    localparam logic [3:0] S_DIV    = 4'd12;
    localparam logic [3:0] S_DIVW   = 4'd13;
    localparam logic [3:0] S_OUT    = 4'd14;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_TIMEOUT = 3'd1;
    localparam logic [2:0] ST_OPEN    = 3'd2;
    localparam logic [2:0] ST_SHORT   = 3'd3;
    localparam logic [2:0] ST_SAT     = 3'd4;

    // register indexes
    localparam logic [1:0] CFG_BETA    = 2'd0;
    localparam logic [1:0] CFG_NOMINAL = 2'd1;
    localparam logic [1:0] CFG_DIVIDER = 2'd2;
    localparam logic [1:0] CFG_OPENLIM = 2'd3;

    // fixed-point constants
    localparam logic [31:0] LN2_Q30     = 32'd744261118;
    localparam logic [31:0] NUM_SCALE   = 32'd2981500;  // 100 * 29815
    localparam logic [31:0] DEN_SCALE   = 32'd6553600;  // 100 * 2^16
    localparam logic [31:0] INV_T0      = 32'd29815;
    localparam int          KELVIN_OFS  = 27315;

    // divider widths
    localparam int NUM_W = 55;
    localparam int DEN_W = 40;
    localparam int Q_W   = 17;
    localparam int REM_W = DEN_W + Q_W;

    typedef struct packed {
        logic done;
        logic ovf;
    } div_stat_t;

endpackage

`default_nettype wire

[design/tbc_div.sv]
// Restoring divider, one quotient bit per cycle, flags quotients that do not fit.
`default_nettype none

module tbc_div
    import tbc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [Q_W-1:0]   quot,
    output div_stat_t             stat
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             ovf_reg, ovf_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [REM_W-1:0] dsh_reg, dsh_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [REM_W-1:0] den_full;
    logic             fits;

    assign den_full = {{(REM_W-DEN_W){1'b0}}, den};
    assign fits     = rem_reg >= dsh_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        if (start) begin
            rem_next = {{(REM_W-NUM_W){1'b0}}, num};
            dsh_next = den_full << (Q_W - 1);
            q_next   = '0;
            cnt_next = 5'(Q_W - 1);
            if ({{(REM_W-NUM_W){1'b0}}, num} >= (den_full << Q_W)) begin
                ovf_next  = 1'b1;
                done_next = 1'b1;
            end else begin
                ovf_next  = 1'b0;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = {q_reg[Q_W-2:0], fits};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ovf_reg  <= ovf_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign quot      = q_reg;
    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;

endmodule

`default_nettype wire

[design/thermistor_average_beta_convert.sv]
// Top level: burst averaging of thermistor conversions and beta-equation temperature.
//
// Input beats (s_*) carry one ADC conversion: sample in s_tdata, channel and
// timeout flag in s_tuser. Each burst drops one settling conversion, then sums
// SAMPLES_PER_READING conversions. A channel change restarts the burst.
// Result beats (m_*) carry the temperature in signed hundredths of a degree C
// on m_tdata, channel and status on m_tuser (0 ok, 1 timeout, 2 open,
// 3 short, 4 saturated high).
// Configuration writes on cfg_* are always taken.
// A conversion that does not end a burst leaves the sequencer idle. A burst end
// runs a sequencer around one shared 32x32 multiplier: two products, two
// log2 passes (6 normalize steps plus 16 squarings each), four more
// products, then a restoring divide, after which the result is loaded into
// the output register when that register is free.
// A timeout or open/short result skips the arithmetic and goes to the output state.
// s_tready is high only while the sequencer is idle; a finished result
// waits in the output state while the output register holds a beat not yet
// taken. Reset restores register defaults and clears the burst state.
`default_nettype none

module thermistor_average_beta_convert
    import tbc_pkg::*;
#(
    parameter int SAMPLES_PER_READING = 16,
    parameter int CHANNEL_COUNT       = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [11:0] sample
    input  wire logic [2:0]  s_tuser,   // [1:0] channel, [2] timed_out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [15:0] temperature_centi
    output logic      [4:0]  m_tuser,   // [1:0] result_channel, [4:2] status
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [19:0] cfg_data
);

    localparam int FULL  = 4095 * SAMPLES_PER_READING;
    localparam int SUM_W = $clog2(FULL + 1);
    localparam int POS_W = $clog2(SAMPLES_PER_READING + 2);
    localparam int XW    = 20 + SUM_W;

    // configuration
    logic [15:0] beta_reg;
    logic [19:0] nom_reg;
    logic [19:0] div_reg;
    logic [15:0] olim_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beta_reg <= 16'd3892;
            nom_reg  <= 20'd10000;
            div_reg  <= 20'd15000;
            olim_reg <= 16'd19;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BETA:    beta_reg <= cfg_data[15:0];
                CFG_NOMINAL: nom_reg  <= cfg_data;
                CFG_DIVIDER: div_reg  <= cfg_data;
                CFG_OPENLIM: olim_reg <= cfg_data[15:0];
                default:     ;
            endcase
        end
    end

    // sequencer and datapath registers
    logic [3:0]        state_reg, state_next;
    logic [1:0]        ch_reg, ch_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SUM_W-1:0]  s_reg, s_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              lsel_reg, lsel_next;
    logic [XW-1:0]     x_reg, x_next;
    logic [5:0]        p_reg, p_next;
    logic [30:0]       m_reg, m_next;
    logic [21:0]       lg_reg, lg_next;
    logic [21:0]       l1_reg, l1_next;
    logic signed [22:0] d_reg, d_next;
    logic [23:0]       lq_reg, lq_next;
    logic              lqneg_reg, lqneg_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic signed [40:0] den_reg, den_next;
    logic [2:0]        rst_reg, rst_next;
    logic [15:0]       rtemp_reg, rtemp_next;

    logic              out_v_reg, out_v_next;
    logic [1:0]        out_ch_reg, out_ch_next;
    logic [15:0]       out_t_reg, out_t_next;
    logic [2:0]        out_s_reg, out_s_next;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    assign prod = mul_a * mul_b;

    // divider
    logic            div_start;
    logic [Q_W-1:0]  div_q;
    div_stat_t       div_st;

    tbc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_reg),
        .den     (den_reg[DEN_W-1:0]),
        .quot    (div_q),
        .stat    (div_st)
    );

    assign div_start = (state_reg == S_DIV);

    // input fields
    logic [1:0]  in_ch;
    logic [11:0] in_smp;
    logic        in_to;
    logic        accept;
    logic        out_free;
    assign in_ch    = s_tuser[1:0];
    assign in_to    = s_tuser[2];
    assign in_smp   = s_tdata[11:0];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_v_reg || m_tready;

    logic [SUM_W-1:0] sum_add;
    logic [22:0]      mag;
    logic [5:0]       k;
    logic [XW-1:0]    xs;
    logic [5:0]       ps;
    logic [31:0]      sq;
    logic signed [18:0] tc;

    assign sum_add = sum_reg + SUM_W'(in_smp);
    assign mag     = d_reg[22] ? 23'(-d_reg) : 23'(d_reg);
    assign k       = 6'(6'd32 >> cnt_reg[2:0]);
    assign sq      = prod[61:30];
    assign tc      = $signed({2'b00, div_q}) - 19'(KELVIN_OFS);

    always_comb begin
        xs = x_reg;
        ps = p_reg;
        if ((x_reg >> (XW - int'(k))) == '0) begin
            xs = x_reg << k;
            ps = p_reg - k;
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL_PN: begin
                mul_a = 32'(div_reg);
                mul_b = 32'(SUM_W'(FULL) - s_reg);
            end
            S_MUL_PD: begin
                mul_a = 32'(s_reg);
                mul_b = 32'(nom_reg);
            end
            S_SQ: begin
                mul_a = 32'(m_reg);
                mul_b = 32'(m_reg);
            end
            S_LN: begin
                mul_a = 32'(mag);
                mul_b = LN2_Q30;
            end
            S_NUM: begin
                mul_a = 32'(beta_reg);
                mul_b = NUM_SCALE;
            end
            S_DENA: begin
                mul_a = 32'(beta_reg);
                mul_b = DEN_SCALE;
            end
            S_DENB: begin
                mul_a = 32'(lq_reg);
                mul_b = INV_T0;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        ch_next     = ch_reg;
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        s_next      = s_reg;
        cnt_next    = cnt_reg;
        lsel_next   = lsel_reg;
        x_next      = x_reg;
        p_next      = p_reg;
        m_next      = m_reg;
        lg_next     = lg_reg;
        l1_next     = l1_reg;
        d_next      = d_reg;
        lq_next     = lq_reg;
        lqneg_next  = lqneg_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        rst_next    = rst_reg;
        rtemp_next  = rtemp_reg;
        out_v_next  = out_v_reg;
        out_ch_next = out_ch_reg;
        out_t_next  = out_t_reg;
        out_s_next  = out_s_reg;

        if (out_v_reg && m_tready) begin
            out_v_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept && (int'(in_ch) < CHANNEL_COUNT)) begin
                    if (pos_reg == '0 || in_ch != ch_reg) begin
                        ch_next  = in_ch;
                        pos_next = POS_W'(1);
                        sum_next = '0;
                    end else if (in_to) begin
                        pos_next   = '0;
                        sum_next   = '0;
                        rst_next   = ST_TIMEOUT;
                        rtemp_next = '0;
                        state_next = S_OUT;
                    end else if (int'(pos_reg) == SAMPLES_PER_READING) begin
                        pos_next   = '0;
                        sum_next   = '0;
                        s_next     = sum_add;
                        state_next = S_CHECK;
                    end else begin
                        sum_next = sum_add;
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
            end
            S_CHECK: begin
                rtemp_next = '0;
                if (32'(s_reg) <= 32'(olim_reg) || nom_reg == '0) begin
                    rst_next   = ST_OPEN;
                    state_next = S_OUT;
                end else if (int'(s_reg) >= FULL || div_reg == '0) begin
                    rst_next   = ST_SHORT;
                    state_next = S_OUT;
                end else begin
                    state_next = S_MUL_PN;
                end
            end
            S_MUL_PN, S_MUL_PD: begin
                // first pass holds log2 of divider branch
                if (state_reg == S_MUL_PD) begin
                    l1_next = lg_reg;
                end
                x_next     = prod[XW-1:0];
                p_next     = 6'(XW - 1);
                cnt_next   = '0;
                lsel_next  = (state_reg == S_MUL_PD);
                state_next = S_NORM;
            end
            S_NORM: begin
                x_next   = xs;
                p_next   = ps;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd5) begin
                    m_next     = xs[XW-1 -: 31];
                    lg_next    = {ps, 16'h0000};
                    cnt_next   = 5'd15;
                    state_next = S_SQ;
                end
            end
            S_SQ: begin
                if (sq[31]) begin
                    m_next = sq[31:1];
                    lg_next[cnt_reg] = 1'b1;
                end else begin
                    m_next = sq[30:0];
                end
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    if (lsel_reg) begin
                        state_next = S_DIFF;
                    end else begin
                        state_next = S_MUL_PD;
                    end
                end
            end
            S_DIFF: begin
                d_next     = $signed({1'b0, l1_reg}) - $signed({1'b0, lg_reg});
                state_next = S_LN;
            end
            S_LN: begin
                // ln in Q16, halves rounded away from zero
                lq_next    = prod[53:30] + 24'(prod[29]);
                lqneg_next = d_reg[22];
                state_next = S_NUM;
            end
            S_NUM: begin
                num_next   = {prod[38:0], 16'h0000};
                state_next = S_DENA;
            end
            S_DENA: begin
                den_next   = $signed({2'b00, prod[38:0]});
                state_next = S_DENB;
            end
            S_DENB: begin
                if (lqneg_reg) begin
                    den_next = den_reg - $signed({1'b0, prod[39:0]});
                end else begin
                    den_next = den_reg + $signed({1'b0, prod[39:0]});
                end
                state_next = S_DENCHK;
            end
            S_DENCHK: begin
                if (den_reg[40] || den_reg == '0) begin
                    rst_next   = ST_SAT;
                    rtemp_next = '0;
                    state_next = S_OUT;
                end else begin
                    num_next   = num_reg + NUM_W'(den_reg[39:1]);
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                state_next = S_DIVW;
            end
            S_DIVW: begin
                if (div_st.done) begin
                    if (div_st.ovf || tc > 19'sd32767) begin
                        rst_next   = ST_SAT;
                        rtemp_next = '0;
                    end else begin
                        rst_next   = ST_OK;
                        rtemp_next = tc[15:0];
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    out_v_next  = 1'b1;
                    out_ch_next = ch_reg;
                    out_t_next  = rtemp_reg;
                    out_s_next  = rst_reg;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ch_reg    <= '0;
            pos_reg   <= '0;
            sum_reg   <= '0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            out_v_reg <= out_v_next;
        end
        s_reg      <= s_next;
        cnt_reg    <= cnt_next;
        lsel_reg   <= lsel_next;
        x_reg      <= x_next;
        p_reg      <= p_next;
        m_reg      <= m_next;
        lg_reg     <= lg_next;
        l1_reg     <= l1_next;
        d_reg      <= d_next;
        lq_reg     <= lq_next;
        lqneg_reg  <= lqneg_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rst_reg    <= rst_next;
        rtemp_reg  <= rtemp_next;
        out_ch_reg <= out_ch_next;
        out_t_reg  <= out_t_next;
        out_s_reg  <= out_s_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_t_reg;
    assign m_tuser  = {out_s_reg, out_ch_reg};

    // a new result beat only comes out of the output state
    a_load_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_v_reg && !$past(out_v_reg)) |-> $past(state_reg == S_OUT))
        else $error("result beat loaded outside output state");

    // any error status carries a zero temperature
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[4:2] != ST_OK) |-> (m_tdata == 16'h0000))
        else $error("nonzero temperature with error status");

    // burst position never runs past the summed length
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(pos_reg) <= SAMPLES_PER_READING)
        else $error("burst position out of range");

    // divider only reports when it was started
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.done |-> (state_reg == S_DIVW))
        else $error("divider finished outside wait state");

endmodule

`default_nettype wire
